// ----- sv/field_centric_mecanum_mixer_macros.svh -----
// Assertion macros for the field-centric mecanum mixer.
// Used by the RTL files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef FIELD_CENTRIC_MECANUM_MIXER_MACROS_SVH
`define FIELD_CENTRIC_MECANUM_MIXER_MACROS_SVH

// Clocked check, off while reset is held
`define FCMM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("fcmm check failed");

// Clocked implication check
`define FCMM_IMPLY(label, ante, cons) \
    `FCMM_ASSERT(label, (ante) |-> (cons))

`endif

// ----- sv/fcmm_pkg.sv -----
// Package for the field-centric mecanum mixer: constants, divider data type, helpers.
// No dependencies.
`default_nettype none
package fcmm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int PCT_W          = 16;
    localparam int FULL_PCT       = 25600;
    localparam int ONE_Q14        = 16384;
    localparam int POLY_A         = 102933;
    localparam int POLY_B         = 42155;
    localparam int POLY_C         = 4765;
    localparam int W_W            = 34;   // wheel sum at Q8.8 * 2^14, signed
    localparam int MAG_W          = 33;   // magnitude of a wheel sum
    localparam int DIV_W          = 49;   // magnitude * 25600
    localparam int QUO_W          = 15;   // quotient, at most 25600
    localparam int LANES          = 4;
    localparam logic [MAG_W-1:0] FULL_SCALED = MAG_W'(FULL_PCT * ONE_Q14);

    typedef struct packed {
        logic [LANES-1:0][DIV_W-1:0] rem;
        logic [MAG_W-1:0]            lim;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][QUO_W-1:0] quo;
    } t_div_data;

    // Clamp a command to +/-100 percent
    function automatic logic signed [PCT_W-1:0] clamp_pct(input logic signed [PCT_W-1:0] v);
        logic signed [PCT_W-1:0] r;
        r = v;
        if (v > PCT_W'(FULL_PCT)) r = PCT_W'(FULL_PCT);
        else if (v < -PCT_W'(FULL_PCT)) r = -PCT_W'(FULL_PCT);
        return r;
    endfunction

    // Round Q16 sine to Q1.14 and saturate at one
    function automatic logic signed [PCT_W-1:0] round_q14(input logic [17:0] s);
        logic [18:0] q;
        q = (19'(s) + 19'd2) >> 2;
        if (q > 19'(ONE_Q14)) q = 19'(ONE_Q14);
        return PCT_W'(q);
    endfunction

endpackage
`default_nettype wire

// ----- sv/fcmm_div_cell.sv -----
// One cell of the divider chain: settles one quotient bit for all four wheels.
// Depends on fcmm_pkg and the macro header.
`default_nettype none
`include "field_centric_mecanum_mixer_macros.svh"
module fcmm_div_cell #(
    parameter int K = 0
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  fcmm_pkg::t_div_data i_data,
    output logic               o_valid,
    input  wire                i_ready,
    output fcmm_pkg::t_div_data o_data
);
    import fcmm_pkg::*;

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;
    logic [DIV_W-1:0] w_trial;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign w_trial = DIV_W'(i_data.lim) << K;

    // Subtract the shifted divisor where it fits
    always_comb begin
        n_data = i_data;
        for (int l = 0; l < LANES; l++) begin
            if (i_data.rem[l] >= w_trial) begin
                n_data.rem[l]    = i_data.rem[l] - w_trial;
                n_data.quo[l][K] = 1'b1;
            end
        end
    end

    // Advance when this cell is empty or the next cell can take the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    `FCMM_IMPLY(a_rem_lane0, r_valid, r_data.rem[0] < (DIV_W'(r_data.lim) << K))
    `FCMM_IMPLY(a_rem_lane3, r_valid, r_data.rem[3] < (DIV_W'(r_data.lim) << K))
    `FCMM_IMPLY(a_lim_floor, r_valid, r_data.lim >= FULL_SCALED)
endmodule
`default_nettype wire

// ----- sv/fcmm_rotate.sv -----
// Front pipeline: clamp, sine/cosine, rotation, wheel mix, limit and dividend.
// Depends on fcmm_pkg and the macro header.
`default_nettype none
`include "field_centric_mecanum_mixer_macros.svh"
module fcmm_rotate #(
    parameter int ANGLE_BITS = fcmm_pkg::ANGLE_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire signed [fcmm_pkg::PCT_W-1:0] i_forward_cmd,
    input  wire signed [fcmm_pkg::PCT_W-1:0] i_strafe_cmd,
    input  wire signed [fcmm_pkg::PCT_W-1:0] i_turn_cmd,
    input  wire        [15:0]          i_heading_angle,
    output logic                       o_valid,
    input  wire                        i_ready,
    output fcmm_pkg::t_div_data        o_data
);
    import fcmm_pkg::*;

    localparam int NST = 8;

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;

    logic [ANGLE_BITS-1:0]   w_phase;
    logic [ANGLE_BITS-3:0]   w_r;
    logic [15:0]             w_t;

    // stage payloads
    logic signed [PCT_W-1:0] r_f [NST-3];
    logic signed [PCT_W-1:0] r_s [NST-3];
    logic signed [PCT_W-1:0] r_tc[NST-3];
    logic [1:0]  r_quad [4];
    logic [16:0] r_ta [4];
    logic [16:0] r_tb [4];
    logic [16:0] r_t2a, r_t2b;
    logic [16:0] r_t2a3, r_t2b3;
    logic [15:0] r_ina, r_inb;
    logic [16:0] r_mida, r_midb;
    logic signed [PCT_W-1:0] r_sn, r_cs;
    logic signed [31:0] r_pfc, r_pss, r_psc, r_pfs, r_ptt;
    logic signed [W_W-1:0] r_w [LANES];
    t_div_data r_out;

    logic [33:0] w_m2a, w_m2b, w_m5a, w_m5b;
    logic [29:0] w_m3a, w_m3b;
    logic [32:0] w_m4a, w_m4b;
    logic signed [PCT_W-1:0] w_a, w_b, n_sn, n_cs;
    logic signed [W_W-1:0] w_rf, w_rs, w_tt;
    logic [LANES-1:0][MAG_W-1:0] w_mag;
    logic [MAG_W-1:0] w_lim;

    // Backpressure through the stages
    always_comb begin
        w_rdy[NST] = i_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
    end
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_data  = r_out;

    // Quantize the heading to ANGLE_BITS per turn
    generate
        if (ANGLE_BITS > 16) begin : g_wide
            assign w_phase = {i_heading_angle, {(ANGLE_BITS - 16){1'b0}}};
        end else begin : g_narrow
            assign w_phase = i_heading_angle[15 -: ANGLE_BITS];
        end
        if (ANGLE_BITS < 18) begin : g_tup
            assign w_t = 16'({w_r, {(18 - ANGLE_BITS){1'b0}}});
        end else begin : g_tdn
            assign w_t = w_r[ANGLE_BITS-3 -: 16];
        end
    endgenerate
    assign w_r = w_phase[ANGLE_BITS-3:0];

    // Polynomial products
    assign w_m2a = r_ta[0] * r_ta[0];
    assign w_m2b = r_tb[0] * r_tb[0];
    assign w_m3a = r_t2a * 13'(POLY_C);
    assign w_m3b = r_t2b * 13'(POLY_C);
    assign w_m4a = r_t2a3 * r_ina;
    assign w_m4b = r_t2b3 * r_inb;
    assign w_m5a = r_ta[3] * r_mida;
    assign w_m5b = r_tb[3] * r_midb;
    assign w_a   = round_q14(w_m5a[33:16]);
    assign w_b   = round_q14(w_m5b[33:16]);

    // Place the quarter-wave values by quadrant
    always_comb begin
        unique case (r_quad[3])
            2'd0: begin n_sn = w_a;  n_cs = w_b;  end
            2'd1: begin n_sn = w_b;  n_cs = -w_a; end
            2'd2: begin n_sn = -w_a; n_cs = -w_b; end
            default: begin n_sn = -w_b; n_cs = w_a; end
        endcase
    end

    // Robot-frame mix
    assign w_rf = W_W'(r_pfc) + W_W'(r_pss);
    assign w_rs = W_W'(r_psc) - W_W'(r_pfs);
    assign w_tt = W_W'(r_ptt);

    // Magnitudes and the normalizing limit
    always_comb begin
        w_lim = FULL_SCALED;
        for (int l = 0; l < LANES; l++) begin
            w_mag[l] = r_w[l][W_W-1] ? MAG_W'(-r_w[l]) : MAG_W'(r_w[l]);
            if (w_mag[l] > w_lim) w_lim = w_mag[l];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int i = 1; i < NST; i++) begin
                if (w_rdy[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_f[0]    <= clamp_pct(i_forward_cmd);
            r_s[0]    <= clamp_pct(i_strafe_cmd);
            r_tc[0]   <= clamp_pct(i_turn_cmd);
            r_quad[0] <= w_phase[ANGLE_BITS-1 -: 2];
            r_ta[0]   <= 17'(w_t);
            r_tb[0]   <= 17'h10000 - 17'(w_t);
        end
        for (int i = 1; i < NST - 3; i++) begin
            if (w_rdy[i]) begin
                r_f[i]  <= r_f[i-1];
                r_s[i]  <= r_s[i-1];
                r_tc[i] <= r_tc[i-1];
            end
        end
        for (int i = 1; i < 4; i++) begin
            if (w_rdy[i]) begin
                r_quad[i] <= r_quad[i-1];
                r_ta[i]   <= r_ta[i-1];
                r_tb[i]   <= r_tb[i-1];
            end
        end
        if (w_rdy[1]) begin
            r_t2a <= w_m2a[32:16];
            r_t2b <= w_m2b[32:16];
        end
        if (w_rdy[2]) begin
            r_t2a3 <= r_t2a;
            r_t2b3 <= r_t2b;
            r_ina  <= 16'(17'(POLY_B) - 17'(w_m3a[29:16]));
            r_inb  <= 16'(17'(POLY_B) - 17'(w_m3b[29:16]));
        end
        if (w_rdy[3]) begin
            r_mida <= 17'(POLY_A) - w_m4a[32:16];
            r_midb <= 17'(POLY_A) - w_m4b[32:16];
        end
        if (w_rdy[4]) begin
            r_sn <= n_sn;
            r_cs <= n_cs;
        end
        if (w_rdy[5]) begin
            r_pfc <= r_f[4] * r_cs;
            r_pss <= r_s[4] * r_sn;
            r_psc <= r_s[4] * r_cs;
            r_pfs <= r_f[4] * r_sn;
            r_ptt <= 32'(r_tc[4]) <<< 14;
        end
        if (w_rdy[6]) begin
            r_w[0] <= w_rf + w_rs + w_tt;
            r_w[1] <= w_rf - w_rs + w_tt;
            r_w[2] <= w_rf - w_rs - w_tt;
            r_w[3] <= w_rf + w_rs - w_tt;
        end
        if (w_rdy[7]) begin
            for (int l = 0; l < LANES; l++) begin
                r_out.rem[l] <= (DIV_W'(w_mag[l]) << 14) + (DIV_W'(w_mag[l]) << 13)
                              + (DIV_W'(w_mag[l]) << 10);
                r_out.neg[l] <= r_w[l][W_W-1];
                r_out.quo[l] <= '0;
            end
            r_out.lim <= w_lim;
        end
    end

    `FCMM_IMPLY(a_sin_range, r_v[4],
        r_sn <= PCT_W'(ONE_Q14) && r_sn >= -PCT_W'(ONE_Q14))
    `FCMM_IMPLY(a_wheel_pairs, r_v[6], r_w[0] + r_w[2] == r_w[1] + r_w[3])
    `FCMM_IMPLY(a_lim_floor, r_v[7], r_out.lim >= FULL_SCALED)
endmodule
`default_nettype wire

// ----- sv/field_centric_mecanum_mixer.sv -----
// Stages: 8 front stages, 15 divider cells and one output register.
// Throughput: one item per cycle unless stalled; 15-cell divider chain sets depth.
// Every stage holds its item while the next one is full, so stalls ripple back.
// Reset: synchronous active low; clears all valid flags only, data is left as is.
// Top level: front pipeline, divider cell chain, output stage. Depends on fcmm_pkg.
`default_nettype none
`include "field_centric_mecanum_mixer_macros.svh"
module field_centric_mecanum_mixer #(
    parameter int ANGLE_BITS = fcmm_pkg::ANGLE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire signed [fcmm_pkg::PCT_W-1:0] i_forward_cmd,
    input  wire signed [fcmm_pkg::PCT_W-1:0] i_strafe_cmd,
    input  wire signed [fcmm_pkg::PCT_W-1:0] i_turn_cmd,
    input  wire        [15:0]                i_heading_angle,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_front_left,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_rear_left,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_front_right,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_rear_right,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_realised_forward,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_realised_strafe,
    output logic signed [fcmm_pkg::PCT_W-1:0] o_realised_turn
);
    import fcmm_pkg::*;

    logic      w_v  [QUO_W+1];
    logic      w_rd [QUO_W+1];
    t_div_data w_d  [QUO_W+1];

    logic r_ov;
    logic w_take;
    logic signed [PCT_W-1:0] w_o [LANES];
    logic signed [17:0] w_sf, w_ss, w_st;

    fcmm_rotate #(.ANGLE_BITS(ANGLE_BITS)) u_rotate (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_forward_cmd   (i_forward_cmd),
        .i_strafe_cmd    (i_strafe_cmd),
        .i_turn_cmd      (i_turn_cmd),
        .i_heading_angle (i_heading_angle),
        .o_valid         (w_v[0]),
        .i_ready         (w_rd[0]),
        .o_data          (w_d[0])
    );

    // Divider chain, most significant quotient bit first
    generate
        for (genvar g = 0; g < QUO_W; g++) begin : g_cell
            fcmm_div_cell #(.K(QUO_W - 1 - g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_v[g]),
                .o_ready (w_rd[g]),
                .i_data  (w_d[g]),
                .o_valid (w_v[g+1]),
                .i_ready (w_rd[g+1]),
                .o_data  (w_d[g+1])
            );
        end
    endgenerate

    assign w_take        = !r_ov || i_out_ready;
    assign w_rd[QUO_W]   = w_take;

    // Restore signs and recover the realised motion
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_o[l] = w_d[QUO_W].neg[l] ? -PCT_W'(w_d[QUO_W].quo[l])
                                       : PCT_W'(w_d[QUO_W].quo[l]);
        end
        w_sf = 18'(w_o[0]) + 18'(w_o[1]) + 18'(w_o[2]) + 18'(w_o[3]);
        w_ss = 18'(w_o[0]) - 18'(w_o[1]) - 18'(w_o[2]) + 18'(w_o[3]);
        w_st = 18'(w_o[0]) + 18'(w_o[1]) - 18'(w_o[2]) - 18'(w_o[3]);
    end

    function automatic logic signed [PCT_W-1:0] div4(input logic signed [17:0] v);
        logic signed [17:0] b;
        b = v + (v[17] ? 18'sd3 : 18'sd0);
        return PCT_W'(b >>> 2);
    endfunction

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= w_v[QUO_W];
        end
        if (w_take) begin
            o_front_left       <= w_o[0];
            o_rear_left        <= w_o[1];
            o_front_right      <= w_o[2];
            o_rear_right       <= w_o[3];
            o_realised_forward <= div4(w_sf);
            o_realised_strafe  <= div4(w_ss);
            o_realised_turn    <= div4(w_st);
        end
    end
    assign o_out_valid = r_ov;

    `FCMM_IMPLY(a_fl_range, r_ov,
        o_front_left <= PCT_W'(FULL_PCT) && o_front_left >= -PCT_W'(FULL_PCT))
    `FCMM_IMPLY(a_rr_range, r_ov,
        o_rear_right <= PCT_W'(FULL_PCT) && o_rear_right >= -PCT_W'(FULL_PCT))
    `FCMM_IMPLY(a_quo_range, w_v[QUO_W], w_d[QUO_W].quo[1] <= QUO_W'(FULL_PCT))
endmodule
`default_nettype wire
